// ===== rtl/core/sli3d_pkg.sv =====
// Package for the 3D segment/line intersection block.
// Widths, item structs and pipeline payload types; no dependencies.
package sli3d_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = 32;
   localparam int DIFF_W     = COORD_BITS + 1;       // coordinate differences
   localparam int CR_W       = 2 * DIFF_W + 1;       // cross product terms
   localparam int COP_P_W    = DIFF_W + CR_W;        // dc * n products
   localparam int COP_W      = COP_P_W + 2;          // dot(dc, n)
   localparam int SQ_P_W     = 2 * CR_W;             // n * n, m * n products
   localparam int DOT_W      = SQ_P_W + 2;           // |n|^2, dot(m, n)
   localparam int REM_W      = DOT_W + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int NCELL      = FRAC_BITS + 1;
   localparam int MUL_W      = Q_W + 1 + DIFF_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [OUT_W-1:0]      fix_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_start_z;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type a_end_z;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_start_z;
      coord_type b_end_x;
      coord_type b_end_y;
      coord_type b_end_z;
   } req_item_type;

   typedef struct packed {
      logic    hit;
      fix_type cross_x;
      fix_type cross_y;
      fix_type cross_z;
   } rsp_item_type;

   // payload handed from one divider cell to the next
   typedef struct packed {
      logic                    ok;
      logic [REM_W-1:0]        rem;
      logic [DOT_W-1:0]        den;
      logic [Q_W-1:0]          q;
      logic [2:0][COORD_BITS-1:0] a1;
      logic [2:0][DIFF_W-1:0]  da;
   } div_data_type;

endpackage

// ===== rtl/core/sli3d_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on sli3d_pkg.
interface sli3d_req_if import sli3d_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sli3d_rsp_if import sli3d_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/segment_line_intersect_3d.sv =====
// Top level of the 3D segment/line intersection block.
// Depends on sli3d_pkg, sli3d_if and sli3d_div_cell.
//
// Use: one request item carries segment A (A1, A2) and line B (B1, B2) as
// signed 16-bit integer points. One response item comes back per request,
// in order: hit plus the crossing point A1 + s*da in Q.16, zeros on a miss.
// Both channels are valid/ready; an item moves when both are high.
// Pipeline: 4 front stages for differences, cross products, dot products
// and checks, 17 divider cells, one multiply stage, one output register.
// Throughput: one item per cycle while rsp ready stays high. Every stage holds its own valid bit and
// fills whenever it is empty or its successor moves, so bubbles collapse.
// The chain of 17 restoring-division cells sets the depth; each cell
// resolves one bit of s.
// Stall: when the receiver holds rsp ready low, the response stays put and
// the pipe keeps taking items until every stage is full, then req ready
// drops.
// Reset: synchronous, clears all valid bits; the pipe comes up empty.
module segment_line_intersect_3d import sli3d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sli3d_req_if.sink   req_chan,
   sli3d_rsp_if.source rsp_chan
);

   // ---------------- stage 1: differences ----------------
   logic                   v1_ff, r1;
   logic [2:0][COORD_BITS-1:0] a1_1_ff;
   diff_type [2:0]         da_1_ff, db_1_ff, dc_1_ff;
   coord_type [2:0]        ia1, ia2, ib1, ib2;

   // ---------------- stage 2: cross products ----------------
   logic                   v2_ff, r2;
   logic [2:0][COORD_BITS-1:0] a1_2_ff;
   diff_type [2:0]         da_2_ff, dc_2_ff;
   logic signed [2:0][CR_W-1:0] n_2_ff, m_2_ff;

   // ---------------- stage 3: products for the dot sums ----------------
   logic                   v3_ff, r3;
   logic [2:0][COORD_BITS-1:0] a1_3_ff;
   diff_type [2:0]         da_3_ff;
   logic signed [2:0][COP_P_W-1:0] cp_3_ff;
   logic signed [2:0][SQ_P_W-1:0]  nn_3_ff, mn_3_ff;

   // ---------------- stage 4: sums and checks ----------------
   logic                   v4_ff, r4;
   div_data_type           d4_ff;
   logic signed [COP_W-1:0] cop_sum;
   logic signed [DOT_W-1:0] den_sum, num_sum;

   // divider chain
   logic         [NCELL:0] cv, cr;
   div_data_type [NCELL:0] cd;

   // ---------------- stage 5: q * da ----------------
   logic                   v5_ff, r5;
   logic                   ok_5_ff;
   logic [2:0][COORD_BITS-1:0] a1_5_ff;
   logic signed [2:0][MUL_W-1:0] p_5_ff;

   // ---------------- output register ----------------
   logic                   vo_ff, ro;
   rsp_item_type           rsp_ff, rsp_in;

   assign ro = !vo_ff || rsp_chan.ready;
   assign r5 = !v5_ff || ro;
   assign r4 = !v4_ff || cr[0];
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign req_chan.ready = r1;

   assign ia1 = {req_chan.data.a_start_z, req_chan.data.a_start_y, req_chan.data.a_start_x};
   assign ia2 = {req_chan.data.a_end_z, req_chan.data.a_end_y, req_chan.data.a_end_x};
   assign ib1 = {req_chan.data.b_start_z, req_chan.data.b_start_y, req_chan.data.b_start_x};
   assign ib2 = {req_chan.data.b_end_z, req_chan.data.b_end_y, req_chan.data.b_end_x};

   always_ff @(posedge clock) begin
      if (r1) begin
         for (int i = 0; i < 3; i++) begin
            a1_1_ff[i] <= ia1[i];
            da_1_ff[i] <= DIFF_W'(ia2[i]) - DIFF_W'(ia1[i]);
            db_1_ff[i] <= DIFF_W'(ib2[i]) - DIFF_W'(ib1[i]);
            dc_1_ff[i] <= DIFF_W'(ib1[i]) - DIFF_W'(ia1[i]);
         end
      end
   end

   // n = da x db, m = dc x db
   always_ff @(posedge clock) begin
      if (r2) begin
         a1_2_ff <= a1_1_ff;
         da_2_ff <= da_1_ff;
         dc_2_ff <= dc_1_ff;
         for (int i = 0; i < 3; i++) begin
            n_2_ff[i] <= CR_W'(da_1_ff[(i+1)%3] * db_1_ff[(i+2)%3])
                       - CR_W'(da_1_ff[(i+2)%3] * db_1_ff[(i+1)%3]);
            m_2_ff[i] <= CR_W'(dc_1_ff[(i+1)%3] * db_1_ff[(i+2)%3])
                       - CR_W'(dc_1_ff[(i+2)%3] * db_1_ff[(i+1)%3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         a1_3_ff <= a1_2_ff;
         da_3_ff <= da_2_ff;
         for (int i = 0; i < 3; i++) begin
            cp_3_ff[i] <= COP_P_W'($signed(dc_2_ff[i]) * $signed(n_2_ff[i]));
            nn_3_ff[i] <= SQ_P_W'($signed(n_2_ff[i]) * $signed(n_2_ff[i]));
            mn_3_ff[i] <= SQ_P_W'($signed(m_2_ff[i]) * $signed(n_2_ff[i]));
         end
      end
   end

   always_comb begin
      cop_sum = COP_W'($signed(cp_3_ff[0])) + COP_W'($signed(cp_3_ff[1]))
              + COP_W'($signed(cp_3_ff[2]));
      den_sum = DOT_W'($signed(nn_3_ff[0])) + DOT_W'($signed(nn_3_ff[1]))
              + DOT_W'($signed(nn_3_ff[2]));
      num_sum = DOT_W'($signed(mn_3_ff[0])) + DOT_W'($signed(mn_3_ff[1]))
              + DOT_W'($signed(mn_3_ff[2]));
   end

   // hit needs: coplanar, not parallel, 0 <= num <= den
   always_ff @(posedge clock) begin
      if (r4) begin
         d4_ff.ok  <= (cop_sum == '0) && (den_sum != '0) && !num_sum[DOT_W-1]
                      && (num_sum <= den_sum);
         d4_ff.rem <= {1'b0, num_sum};
         d4_ff.den <= den_sum;
         d4_ff.q   <= '0;
         d4_ff.a1  <= a1_3_ff;
         d4_ff.da  <= da_3_ff;
      end
   end

   assign cv[0] = v4_ff;
   assign cd[0] = d4_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      sli3d_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cv[g]),
         .up_data  (cd[g]),
         .up_ready (cr[g]),
         .dn_valid (cv[g+1]),
         .dn_ready (cr[g+1]),
         .dn_data  (cd[g+1])
      );
   end

   assign cr[NCELL] = r5;

   always_ff @(posedge clock) begin
      if (r5) begin
         ok_5_ff <= cd[NCELL].ok;
         a1_5_ff <= cd[NCELL].a1;
         for (int i = 0; i < 3; i++) begin
            p_5_ff[i] <= MUL_W'($signed({1'b0, cd[NCELL].q}) * $signed(cd[NCELL].da[i]));
         end
      end
   end

   // A1 * 2^F + q * da, wrapped to the output width; zeros on a miss
   always_comb begin
      fix_type c [3];
      for (int i = 0; i < 3; i++) begin
         c[i] = (OUT_W'($signed(a1_5_ff[i])) <<< FRAC_BITS) + p_5_ff[i][OUT_W-1:0];
         if (!ok_5_ff) begin
            c[i] = '0;
         end
      end
      rsp_in.hit     = ok_5_ff;
      rsp_in.cross_x = c[0];
      rsp_in.cross_y = c[1];
      rsp_in.cross_z = c[2];
   end

   always_ff @(posedge clock) begin
      if (ro) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_chan.valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= cv[NCELL];
         if (ro) vo_ff <= v5_ff;
      end
   end

   assign rsp_chan.valid = vo_ff;
   assign rsp_chan.data  = rsp_ff;

endmodule

// ===== rtl/core/sli3d_div_cell.sv =====
// One restoring-division cell: settles one quotient bit and passes on.
// Depends on sli3d_pkg.
module sli3d_div_cell import sli3d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   input  div_data_type up_data,
   output logic         up_ready,
   output logic         dn_valid,
   input  logic         dn_ready,
   output div_data_type dn_data
);

   logic         valid_ff;
   div_data_type data_ff, data_in;
   logic         ge;
   logic [REM_W-1:0] diff;

   always_comb begin
      ge   = up_data.rem >= {1'b0, up_data.den};
      diff = ge ? (up_data.rem - {1'b0, up_data.den}) : up_data.rem;
      data_in     = up_data;
      data_in.rem = {diff[REM_W-2:0], 1'b0};
      data_in.q   = {up_data.q[Q_W-2:0], ge};
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/sli3d_checker.sv =====
// Port-level checks for segment_line_intersect_3d, attached by bind.
// Depends on sli3d_pkg and sli3d_if.
module sli3d_checker import sli3d_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // a miss reports the origin
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && rsp_data.cross_z == '0)
      else $error("miss with nonzero point");

   // pipe comes up empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   // rsp valid never rises straight out of reset
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1))
      else $error("item out of reset");

endmodule

bind segment_line_intersect_3d sli3d_checker u_sli3d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
